// File: hw/rtl/svdg_pkg.sv
// Shared types and constants for the space-vector PWM duty generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package svdg_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_SUPPLY = 8'd0;
  localparam logic [7:0] CFG_PERIOD = 8'd1;

  localparam logic [15:0] SUPPLY_RESET = 16'd12000;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // Fixed-point constants (unsigned Q1.30 unless noted; the magnitude limits are integers)
  localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
  localparam logic [30:0] PI_3_Q30     = 31'd1124419809;
  localparam logic [30:0] SQRT3_Q30    = 31'd1859775393;
  localparam logic [14:0] MAG_LIMIT    = 15'd18907;
  localparam logic [14:0] MAG_LIMIT_P1 = 15'd18908;

  // Exact reciprocals for 31-bit dividends: floor(x/d) = (x*M) >> (31+l)
  localparam logic [31:0] RECIP_42 = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam logic [31:0] RECIP_20 = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [31:0] RECIP_6  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);

  localparam int unsigned SQRT_STAGES = 31;
  localparam int unsigned DIV_STAGES  = 15;
  localparam int unsigned SIN_STAGES  = 10;

  typedef struct packed {
    logic [31:0] sq;      // ud^2 + uq^2
    logic [15:0] pos;     // position inside the sector, 65536 = 60 degrees
    logic [2:0]  sector;  // 1..6
  } item_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [2:0]  sector;
  } side_t;

  typedef struct packed {
    logic        full;
    logic        empty;
    logic [2:0]  count;
  } q_stat_t;

endpackage

// File: hw/rtl/svdg_front.sv
// Front part: accepts input items, shifts the angle, finds sector and position,
// and forms the squared vector length. Depends on svdg_pkg.
`timescale 1ns / 1ps
module svdg_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [47:0]          s_axis_tdata_i,  // uq[15:0], ud[31:16], angle[47:32]
  input  logic                 q_full_i,
  output logic                 push_o,
  output svdg_pkg::item_t      item_o
);
  import svdg_pkg::*;

  logic              valid_q, valid_d;
  item_t             item_q, item_d;
  logic signed [15:0] uq, ud;
  logic [15:0]       ang_sh;
  logic [18:0]       scaled;
  logic [16:0]       auq, aud;
  logic [33:0]       sq_uq, sq_ud;

  assign uq = s_axis_tdata_i[15:0];
  assign ud = s_axis_tdata_i[31:16];

  always_comb begin
    // +90 degrees for positive uq, -90 degrees otherwise
    if (uq > 16'sd0) begin
      ang_sh = s_axis_tdata_i[47:32] + 16'd16384;
    end else begin
      ang_sh = s_axis_tdata_i[47:32] - 16'd16384;
    end
    scaled = 19'(ang_sh) * 19'd6;
    auq    = uq[15] ? 17'(-{uq[15], uq}) : {1'b0, uq};
    aud    = ud[15] ? 17'(-{ud[15], ud}) : {1'b0, ud};
    sq_uq  = auq * auq;
    sq_ud  = aud * aud;
    item_d.sq     = 32'(sq_uq + sq_ud);
    item_d.pos    = scaled[15:0];
    item_d.sector = scaled[18:16] + 3'd1;
  end

  assign s_axis_tready_o = !valid_q || !q_full_i;
  assign push_o          = valid_q && !q_full_i;
  assign valid_d         = s_axis_tready_o ? s_axis_tvalid_i : valid_q;
  assign item_o          = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      item_q <= item_d;
    end
  end

endmodule

// File: hw/rtl/svdg_queue.sv
// Short queue decoupling the front from the back pipeline.
// Depends on svdg_pkg for the item type and depth.
`timescale 1ns / 1ps
module svdg_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  svdg_pkg::item_t      item_i,
  input  logic                 pop_i,
  output svdg_pkg::item_t      item_o,
  output svdg_pkg::q_stat_t    stat_o
);
  import svdg_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign stat_o.count = 3'(cnt_q);
  assign stat_o.full  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: hw/rtl/svdg_back.sv
// Back part: pipelined square root, saturating divide, sine polynomial,
// dwell times and duty scaling with an output register. Depends on svdg_pkg.
`timescale 1ns / 1ps
module svdg_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  svdg_pkg::item_t      item_i,
  output logic                 pop_o,
  input  logic [15:0]          supply_i,
  input  logic [15:0]          period_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [47:0]          m_axis_tdata_o  // duty_a[15:0], duty_b[31:16], duty_c[47:32]
);
  import svdg_pkg::*;

  typedef struct packed {
    logic        vld;
    logic [31:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
    side_t       side;
  } sqs_t;

  typedef struct packed {
    logic        vld;
    logic        sat;
    logic [30:0] rem;
    logic [14:0] quo;
    side_t       side;
  } dvs_t;

  logic  en;
  sqs_t  sq0;
  sqs_t  sq_q [1:SQRT_STAGES];
  dvs_t  dv_q [0:DIV_STAGES];
  logic  [30:0] thr_q;

  // sine lanes: lane 0 gives T1, lane 1 gives T2
  logic        sn_v_q   [0:SIN_STAGES-1];
  side_t       sn_side_q[0:SIN_STAGES-1];
  logic [14:0] sn_mag_q [0:SIN_STAGES-1];
  logic [30:0] sn_x_q   [0:SIN_STAGES-1][0:1];
  logic [30:0] sn_x2_q  [0:SIN_STAGES-1][0:1];
  logic [30:0] sn_w_q   [0:SIN_STAGES-1][0:1];

  logic        f_v_q;
  logic [31:0] fa_q, fb_q, fc_q;
  logic        out_v_q;
  logic [47:0] out_q;

  // Whole pipeline advances unless a result waits at the output
  assign en    = !out_v_q || m_axis_tready_i;
  assign pop_o = en;

  // Threshold for saturation: root >= 18908 * supply means quotient > limit
  always_ff @(posedge clk_i) begin
    thr_q <= 31'(supply_i) * 31'(MAG_LIMIT_P1);
  end

  // ---------------- square root, one result bit per stage ----------------
  assign sq0.vld  = in_valid_i;
  assign sq0.rem  = '0;
  assign sq0.root = '0;
  assign sq0.rad  = {item_i.sq, 30'd0};
  assign sq0.side = '{pos: item_i.pos, sector: item_i.sector};

  for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
    sqs_t prv, nxt;
    logic [33:0] r2, trial;
    if (k == 1) begin : g_first
      assign prv = sq0;
    end else begin : g_next
      assign prv = sq_q[k-1];
    end
    always_comb begin
      r2       = {prv.rem, prv.rad[61:60]};
      trial    = {1'b0, prv.root, 2'b01};
      nxt      = prv;
      nxt.rad  = {prv.rad[59:0], 2'b00};
      if (r2 >= trial) begin
        nxt.rem  = 32'(r2 - trial);
        nxt.root = {prv.root[29:0], 1'b1};
      end else begin
        nxt.rem  = r2[31:0];
        nxt.root = {prv.root[29:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[k] <= '0;
      end else if (en) begin
        sq_q[k] <= nxt;
      end
    end
  end

  // ---------------- divide by supply, restoring, one bit per stage --------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (en) begin
      dv_q[0] <= '{vld:  sq_q[SQRT_STAGES].vld,
                   sat:  (supply_i == '0) || (sq_q[SQRT_STAGES].root >= thr_q),
                   rem:  sq_q[SQRT_STAGES].root,
                   quo:  15'd0,
                   side: sq_q[SQRT_STAGES].side};
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    localparam int unsigned Bit = DIV_STAGES - 1 - j;
    logic [30:0] dsr;
    logic        ge;
    dvs_t        dv_nxt;
    assign dsr = 31'(supply_i) << Bit;
    assign ge  = dv_q[j].rem >= dsr;
    always_comb begin
      dv_nxt = dv_q[j];
      if (ge) begin
        dv_nxt.rem      = dv_q[j].rem - dsr;
        dv_nxt.quo[Bit] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= '0;
      end else if (en) begin
        dv_q[j+1] <= dv_nxt;
      end
    end
  end

  // ---------------- sine polynomial, one product per stage ----------------
  function automatic logic [30:0] sin_step(input int unsigned j, input logic [30:0] x,
                                           input logic [30:0] x2, input logic [30:0] w,
                                           input logic [14:0] mag);
    logic [30:0] t;
    logic [63:0] p;
    t = Q30_ONE - w;
    unique case (j)
      1:       p = (64'(x) * 64'(x)) >> 30;
      2:       p = (64'(x2) * 64'(RECIP_42)) >> 37;
      3:       p = (64'(x2) * 64'(t)) >> 30;
      4:       p = (64'(w) * 64'(RECIP_20)) >> 36;
      5:       p = (64'(x2) * 64'(t)) >> 30;
      6:       p = (64'(w) * 64'(RECIP_6)) >> 34;
      7:       p = (64'(x) * 64'(t)) >> 30;
      8:       p = (64'(w) * 64'(SQRT3_Q30)) >> 30;
      9:       p = (64'(w) * 64'(mag)) >> 15;
      default: p = 64'(w);
    endcase
    return p[30:0];
  endfunction

  logic [14:0] mag0;
  logic [16:0] n0 [0:1];
  assign mag0  = dv_q[DIV_STAGES].sat ? MAG_LIMIT : dv_q[DIV_STAGES].quo;
  assign n0[0] = 17'h1_0000 - {1'b0, dv_q[DIV_STAGES].side.pos};
  assign n0[1] = {1'b0, dv_q[DIV_STAGES].side.pos};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn_v_q[0] <= 1'b0;
    end else if (en) begin
      sn_v_q[0] <= dv_q[DIV_STAGES].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_side_q[0] <= dv_q[DIV_STAGES].side;
      sn_mag_q[0]  <= mag0;
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane0
    logic [47:0] px;
    assign px = 48'(n0[ln]) * 48'(PI_3_Q30);
    always_ff @(posedge clk_i) begin
      if (en) begin
        sn_x_q[0][ln]  <= px[46:16];
        sn_x2_q[0][ln] <= '0;
        sn_w_q[0][ln]  <= '0;
      end
    end
  end

  for (genvar j = 1; j < SIN_STAGES; j++) begin : g_sin
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sn_v_q[j] <= 1'b0;
      end else if (en) begin
        sn_v_q[j] <= sn_v_q[j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sn_side_q[j] <= sn_side_q[j-1];
        sn_mag_q[j]  <= sn_mag_q[j-1];
      end
    end
    for (genvar ln = 0; ln < 2; ln++) begin : g_ln
      logic [30:0] w_new;
      assign w_new = sin_step(j, sn_x_q[j-1][ln], sn_x2_q[j-1][ln], sn_w_q[j-1][ln],
                              sn_mag_q[j-1]);
      always_ff @(posedge clk_i) begin
        if (en) begin
          sn_x_q[j][ln]  <= sn_x_q[j-1][ln];
          sn_x2_q[j][ln] <= (j == 1) ? w_new : sn_x2_q[j-1][ln];
          sn_w_q[j][ln]  <= w_new;
        end
      end
    end
  end

  // ---------------- dwell times and sector mapping ----------------
  logic [30:0] t1, t2, t0;
  logic [31:0] tsum, full, one1, one2, t0w;
  logic [31:0] da, db, dc;

  always_comb begin
    t1   = sn_w_q[SIN_STAGES-1][0];
    t2   = sn_w_q[SIN_STAGES-1][1];
    tsum = 32'(t1) + 32'(t2);
    t0   = (tsum >= 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - tsum);
    t0w  = 32'(t0);
    full = 32'(tsum << 1) + t0w;
    one1 = 32'({t1, 1'b0}) + t0w;
    one2 = 32'({t2, 1'b0}) + t0w;
    unique case (sn_side_q[SIN_STAGES-1].sector)
      3'd1:    begin da = full; db = one2; dc = t0w;  end
      3'd2:    begin da = one1; db = full; dc = t0w;  end
      3'd3:    begin da = t0w;  db = full; dc = one2; end
      3'd4:    begin da = t0w;  db = one1; dc = full; end
      3'd5:    begin da = one2; db = t0w;  dc = full; end
      3'd6:    begin da = full; db = t0w;  dc = one1; end
      default: begin da = '0;   db = '0;   dc = '0;   end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= sn_v_q[SIN_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fa_q <= da;
      fb_q <= db;
      fc_q <= dc;
    end
  end

  // ---------------- period scaling into the output register ----------------
  logic [47:0] pa, pb, pc;
  assign pa = 48'(fa_q) * 48'(period_i);
  assign pb = 48'(fb_q) * 48'(period_i);
  assign pc = 48'(fc_q) * 48'(period_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {pc[46:31], pb[46:31], pa[46:31]};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

endmodule

// File: hw/rtl/svpwm_duty_generator_top.sv
// Top level of the space-vector PWM duty generator with inverse Park.
// Depends on svdg_pkg, svdg_front, svdg_queue and svdg_back.
`timescale 1ns / 1ps
// Usage:
//   Input stream (s_axis_*): one item per handshake carrying uq and ud in signed
//   millivolts and the electrical angle (65536 units per turn).
//   Output stream (m_axis_*): one item per input with the three compare values.
//   Config channel (cfg_*): index 0 writes the supply voltage in mV, index 1 the
//   PWM period in counts; other indexes are dropped. cfg_ready_o is always high.
//   Write configuration only while no item is in flight.
// Throughput: one item per cycle while the receiver keeps m_axis_tready_i high.
//   The front stage computes sector, position and the squared length; a
//   four-item queue decouples it from the back pipeline (31 square-root stages,
//   16 divide stages, 10 sine stages, dwell-time mapping and the period multiply
//   into the output register).
// Reset: asynchronous, active low; clears all valid bits, empties the queue and
//   loads supply 12000 mV and period 1000 counts.
// Stall: when the receiver holds m_axis_tready_i low, the back pipeline freezes
//   while the front keeps filling the queue; s_axis_tready_o drops once the
//   queue and the front register are both full.
module svpwm_duty_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // uq_millivolts, ud_millivolts, electrical_angle
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // duty_phase_a, duty_phase_b, duty_phase_c
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import svdg_pkg::*;

  logic [15:0] supply_q, supply_d;
  logic [15:0] period_q, period_d;
  logic        push, pop;
  item_t       f_item, q_item;
  q_stat_t     q_stat;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  always_comb begin
    supply_d = supply_q;
    period_d = period_q;
    if (cfg_valid_i && (cfg_index_i == CFG_SUPPLY)) begin
      supply_d = cfg_data_i;
    end
    if (cfg_valid_i && (cfg_index_i == CFG_PERIOD)) begin
      period_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RESET;
      period_q <= PERIOD_RESET;
    end else begin
      supply_q <= supply_d;
      period_q <= period_d;
    end
  end

  svdg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_stat.full),
    .push_o          (push),
    .item_o          (f_item)
  );

  svdg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  svdg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (!q_stat.empty),
    .item_i          (q_item),
    .pop_o           (pop),
    .supply_i        (supply_q),
    .period_i        (period_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Queue fill never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= 3'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // Front only stalls the input when the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_stat.full)
    else $error("input stalled with queue space left");

  // Zero period yields all-zero duties
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (period_q == '0)) |-> (m_axis_tdata_o == '0))
    else $error("nonzero duty with zero period");

endmodule
